// ----- src/cis_pkg.sv -----
// Shared types and constants for the 2-D inverse-CDF importance sampler.
// No dependencies; imported by the interfaces and every module of the block.
package cis_pkg;

    localparam int CMD_W      = 1;
    localparam int PW_W       = 16;
    localparam int U_W        = 16;
    localparam int ROW_IDX_W  = 7;
    localparam int COL_IDX_W  = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;
    localparam int CFG_W_W    = 9;
    localparam int CFG_H_W    = 8;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    localparam logic STATUS_OK         = 1'b0;
    localparam logic STATUS_NOT_LOADED = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;

    localparam logic [CFG_W_W-1:0] WIDTH_RESET  = 9'd256;
    localparam logic [CFG_H_W-1:0] HEIGHT_RESET = 8'd128;

    typedef struct packed {
        logic            cmd;
        logic [PW_W-1:0] pixel_weight;
        logic [U_W-1:0]  u_row;
        logic [U_W-1:0]  u_col;
    } t_item;

    typedef struct packed {
        logic  valid;
        t_item item;
    } t_queue_head;

    typedef struct packed {
        logic busy;
        logic loaded;
    } t_back_stat;

endpackage

// ----- src/cis_in_if.sv -----
// Input item channel: valid/ready handshake with the command and its operands.
// Depends on cis_pkg for field widths.
interface cis_in_if;
    import cis_pkg::*;

    logic            valid;
    logic            ready;
    logic            cmd;
    logic [PW_W-1:0] pixel_weight;
    logic [U_W-1:0]  u_row;
    logic [U_W-1:0]  u_col;

    modport source (output valid, cmd, pixel_weight, u_row, u_col, input ready);
    modport sink   (input valid, cmd, pixel_weight, u_row, u_col, output ready);
endinterface

// ----- src/cis_out_if.sv -----
// Result item channel: valid/ready handshake with status and sampled indices.
// Depends on cis_pkg for field widths.
interface cis_out_if;
    import cis_pkg::*;

    logic                 valid;
    logic                 ready;
    logic                 status;
    logic [ROW_IDX_W-1:0] row_index;
    logic [COL_IDX_W-1:0] col_index;

    modport source (output valid, status, row_index, col_index, input ready);
    modport sink   (input valid, status, row_index, col_index, output ready);
endinterface

// ----- src/cis_front.sv -----
// Front end: accepts input items and holds them in a short queue for the back end.
// Depends on cis_pkg and cis_in_if.
module cis_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    cis_in_if.sink               i_item,
    input  logic                 i_pop,
    output cis_pkg::t_queue_head o_head
);
    import cis_pkg::*;

    t_item             r_q [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QPTR_W:0]   r_count;
    logic              w_push;

    assign i_item.ready = (r_count != (QPTR_W + 1)'(QUEUE_DEPTH));
    assign w_push       = i_item.valid && i_item.ready;

    assign o_head.valid = (r_count != '0);
    assign o_head.item  = r_q[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr_ptr] <= '{cmd:          i_item.cmd,
                               pixel_weight: i_item.pixel_weight,
                               u_row:        i_item.u_row,
                               u_col:        i_item.u_col};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            unique case ({w_push, i_pop})
                2'b10:   r_count <= r_count + (QPTR_W + 1)'(1);
                2'b01:   r_count <= r_count - (QPTR_W + 1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ----- src/cis_back.sv -----
// Back end: builds the prefix tables on loads, runs the two binary searches on samples
// and holds the result register. Depends on cis_pkg and cis_out_if.
module cis_back #(
    parameter int MAX_WIDTH   = 256,
    parameter int MAX_HEIGHT  = 128,
    parameter int WEIGHT_BITS = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [cis_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [cis_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  cis_pkg::t_queue_head              i_head,
    output logic                              o_pop,
    output cis_pkg::t_back_stat               o_stat,
    cis_out_if.source                         o_res
);
    import cis_pkg::*;

    localparam int CW     = $clog2(MAX_WIDTH);
    localparam int RW     = $clog2(MAX_HEIGHT);
    localparam int WB     = (WEIGHT_BITS < PW_W) ? WEIGHT_BITS : PW_W;
    localparam int SW     = WB + CW;
    localparam int TW     = SW + RW;
    localparam int IW     = (RW > CW) ? RW : CW;
    localparam int CDEPTH = 1 << (RW + CW);
    localparam int RDEPTH = 1 << RW;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_MUL1 = 4'd1;
    localparam logic [3:0] S_ADDR = 4'd2;
    localparam logic [3:0] S_CMP  = 4'd3;
    localparam logic [3:0] S_RT0  = 4'd4;
    localparam logic [3:0] S_RT1  = 4'd5;
    localparam logic [3:0] S_SUB  = 4'd6;
    localparam logic [3:0] S_MUL2 = 4'd7;
    localparam logic [3:0] S_DONE = 4'd8;

    logic [SW-1:0] m_col [CDEPTH];
    logic [TW-1:0] m_row [RDEPTH];

    logic [CFG_W_W-1:0] r_cfg_w;
    logic [CFG_H_W-1:0] r_cfg_h;
    logic [CW-1:0]      w_last;
    logic [RW-1:0]      h_last;

    logic [RW-1:0] r_ld_row;
    logic [CW-1:0] r_ld_col;
    logic [SW-1:0] r_sum;
    logic [TW-1:0] r_cum;
    logic          r_loaded;

    logic [3:0]     r_state;
    logic [U_W-1:0] r_u_row;
    logic [U_W-1:0] r_u_col;
    logic [TW-1:0]  r_t;
    logic [IW-1:0]  r_lo;
    logic [IW-1:0]  r_hi;
    logic [IW-1:0]  r_mid;
    logic           r_phase;
    logic [RW-1:0]  r_row_sel;
    logic [TW-1:0]  r_ptop;
    logic [SW-1:0]  r_rtotal;
    logic [TW-1:0]  r_row_rd;
    logic [SW-1:0]  r_col_rd;

    logic                 r_o_valid;
    logic                 r_o_status;
    logic [ROW_IDX_W-1:0] r_o_row;
    logic [COL_IDX_W-1:0] r_o_col;

    logic          w_restart;
    logic [RW-1:0] w_row;
    logic [CW-1:0] w_col;
    logic [SW-1:0] w_sum;
    logic [TW-1:0] w_cum_base;
    logic [TW-1:0] w_cum;
    logic          w_row_end;
    logic          w_map_end;
    logic          w_idle;
    logic          w_do_load;
    logic          w_is_sample;
    logic          w_out_free;
    logic          w_out_early;
    logic          w_out_done;

    logic [IW:0]           w_mid_sum;
    logic [IW-1:0]         w_mid;
    logic [RW-1:0]         w_row_raddr;
    logic [TW-1:0]         w_probe;
    logic                  w_hit;
    logic [IW-1:0]         n_lo;
    logic [IW-1:0]         n_hi;
    logic [U_W+TW-1:0]     w_prod1;
    logic [U_W+SW-1:0]     w_prod2;
    logic [TW-1:0]         w_prev;
    logic [TW-1:0]         w_diff;
    logic [RW+ROW_IDX_W-1:0] w_row_ext;
    logic [CW+COL_IDX_W-1:0] w_col_ext;

    // effective dimensions, saturated to the supported range
    always_comb begin
        if (r_cfg_w == '0) begin
            w_last = '0;
        end else if (int'(r_cfg_w) > MAX_WIDTH) begin
            w_last = CW'(MAX_WIDTH - 1);
        end else begin
            w_last = CW'(int'(r_cfg_w) - 1);
        end
        if (r_cfg_h == '0) begin
            h_last = '0;
        end else if (int'(r_cfg_h) > MAX_HEIGHT) begin
            h_last = RW'(MAX_HEIGHT - 1);
        end else begin
            h_last = RW'(int'(r_cfg_h) - 1);
        end
    end

    assign w_idle      = (r_state == S_IDLE);
    assign w_is_sample = (i_head.item.cmd == CMD_SAMPLE);
    assign w_do_load   = w_idle && i_head.valid && !w_is_sample;
    assign w_out_free  = !r_o_valid || o_res.ready;
    assign w_out_early = w_idle && i_head.valid && w_is_sample && !r_loaded && w_out_free;
    assign w_out_done  = (r_state == S_DONE) && w_out_free;
    assign o_pop       = w_idle && i_head.valid && (!w_is_sample || r_loaded || w_out_free);

    assign o_stat.busy   = !w_idle;
    assign o_stat.loaded = r_loaded;

    // load path
    assign w_restart  = r_loaded || (r_ld_row > h_last) || (r_ld_col > w_last);
    assign w_row      = w_restart ? '0 : r_ld_row;
    assign w_col      = w_restart ? '0 : r_ld_col;
    assign w_sum      = (w_restart ? '0 : r_sum) + SW'(i_head.item.pixel_weight[WB-1:0]);
    assign w_cum_base = w_restart ? '0 : r_cum;
    assign w_cum      = w_cum_base + TW'(w_sum);
    assign w_row_end  = (w_col == w_last);
    assign w_map_end  = w_row_end && (w_row == h_last);

    always_ff @(posedge i_clk) begin
        if (w_do_load) begin
            m_col[{w_row, w_col}] <= w_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_load && w_row_end) begin
            m_row[w_row] <= w_cum;
        end
    end

    // search path
    assign w_mid_sum = {1'b0, r_lo} + {1'b0, r_hi};
    assign w_mid     = w_mid_sum[IW:1];

    always_comb begin
        priority if (r_state == S_ADDR) begin
            w_row_raddr = w_mid[RW-1:0];
        end else if (r_state == S_RT1) begin
            w_row_raddr = r_lo[RW-1:0] - RW'(1);
        end else begin
            w_row_raddr = r_lo[RW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        r_row_rd <= m_row[w_row_raddr];
        r_col_rd <= m_col[{r_row_sel, w_mid[CW-1:0]}];
    end

    assign w_probe = r_phase ? TW'(r_col_rd) : r_row_rd;
    assign w_hit   = (w_probe > r_t);
    assign n_lo    = w_hit ? r_lo : r_mid + IW'(1);
    assign n_hi    = w_hit ? r_mid : r_hi;

    assign w_prod1 = (U_W + TW)'(r_u_row) * (U_W + TW)'(r_cum);
    assign w_prod2 = (U_W + SW)'(r_u_col) * (U_W + SW)'(r_rtotal);
    assign w_prev  = (r_lo == '0) ? '0 : r_row_rd;
    assign w_diff  = r_ptop - w_prev;

    assign w_row_ext = {{ROW_IDX_W{1'b0}}, r_row_sel};
    assign w_col_ext = {{COL_IDX_W{1'b0}}, r_lo[CW-1:0]};

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_idle && o_pop && w_is_sample) begin
            r_u_row <= i_head.item.u_row;
            r_u_col <= i_head.item.u_col;
        end
        if (r_state == S_MUL1) begin
            r_t <= w_prod1[U_W+TW-1:U_W];
        end else if (r_state == S_MUL2) begin
            r_t <= TW'(w_prod2[U_W+SW-1:U_W]);
        end
        if (r_state == S_ADDR) begin
            r_mid <= w_mid;
        end
        if (r_state == S_RT0) begin
            r_row_sel <= r_lo[RW-1:0];
        end
        if (r_state == S_RT1) begin
            r_ptop <= r_row_rd;
        end
        if (r_state == S_SUB) begin
            r_rtotal <= SW'(w_diff);
        end
        if (w_out_early) begin
            r_o_status <= STATUS_NOT_LOADED;
            r_o_row    <= '0;
            r_o_col    <= '0;
        end else if (w_out_done) begin
            r_o_status <= STATUS_OK;
            r_o_row    <= w_row_ext[ROW_IDX_W-1:0];
            r_o_col    <= w_col_ext[COL_IDX_W-1:0];
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w   <= WIDTH_RESET;
            r_cfg_h   <= HEIGHT_RESET;
            r_ld_row  <= '0;
            r_ld_col  <= '0;
            r_sum     <= '0;
            r_cum     <= '0;
            r_loaded  <= 1'b0;
            r_state   <= S_IDLE;
            r_lo      <= '0;
            r_hi      <= '0;
            r_phase   <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            priority if (i_cfg_we && (i_cfg_idx == CFG_WIDTH || i_cfg_idx == CFG_HEIGHT)) begin
                if (i_cfg_idx == CFG_WIDTH) begin
                    r_cfg_w <= i_cfg_data;
                end else begin
                    r_cfg_h <= i_cfg_data[CFG_H_W-1:0];
                end
                r_ld_row <= '0;
                r_ld_col <= '0;
                r_sum    <= '0;
                r_cum    <= '0;
                r_loaded <= 1'b0;
            end else if (w_do_load) begin
                if (w_row_end) begin
                    r_sum    <= '0;
                    r_ld_col <= '0;
                    r_cum    <= w_cum;
                    if (w_map_end) begin
                        r_ld_row <= '0;
                        r_loaded <= 1'b1;
                    end else begin
                        r_ld_row <= w_row + RW'(1);
                        r_loaded <= 1'b0;
                    end
                end else begin
                    r_sum    <= w_sum;
                    r_ld_col <= w_col + CW'(1);
                    r_ld_row <= w_row;
                    r_cum    <= w_cum_base;
                    r_loaded <= 1'b0;
                end
            end else begin
                r_loaded <= r_loaded;
            end

            if (w_out_early || w_out_done) begin
                r_o_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_o_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (o_pop && w_is_sample && r_loaded) begin
                        r_state <= S_MUL1;
                    end
                end
                S_MUL1: begin
                    r_phase <= 1'b0;
                    r_lo    <= '0;
                    r_hi    <= IW'(h_last);
                    r_state <= (h_last == '0) ? S_RT0 : S_ADDR;
                end
                S_ADDR: begin
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    r_lo <= n_lo;
                    r_hi <= n_hi;
                    if (n_lo == n_hi) begin
                        r_state <= r_phase ? S_DONE : S_RT0;
                    end else begin
                        r_state <= S_ADDR;
                    end
                end
                S_RT0: begin
                    r_state <= S_RT1;
                end
                S_RT1: begin
                    r_state <= S_SUB;
                end
                S_SUB: begin
                    r_state <= S_MUL2;
                end
                S_MUL2: begin
                    r_phase <= 1'b1;
                    r_lo    <= '0;
                    r_hi    <= IW'(w_last);
                    r_state <= (w_last == '0) ? S_DONE : S_ADDR;
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_res.valid     = r_o_valid;
    assign o_res.status    = r_o_status;
    assign o_res.row_index = r_o_row;
    assign o_res.col_index = r_o_col;

endmodule

// ----- src/cdf_importance_sampler_2d_unit.sv -----
// Top level of the 2-D inverse-CDF importance sampler: input queue front end and
// table-building / binary-search back end. Depends on cis_pkg, cis_in_if, cis_out_if.
// Loads: one item per cycle while the back end is not busy with a sample; no result.
// Samples: a binary search over the row table, then one over the chosen row's column
// table, each probe on a registered read port; no new item is taken until the result is out.
// Reset clears control and the loaded flag; table contents are undefined until loaded.
module cdf_importance_sampler_2d_unit #(
    parameter int MAX_WIDTH   = 256,
    parameter int MAX_HEIGHT  = 128,
    parameter int WEIGHT_BITS = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [cis_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [cis_pkg::CFG_DATA_W-1:0] i_cfg_data,
    cis_in_if.sink                         i_item,
    cis_out_if.source                      o_res
);
    import cis_pkg::*;

    t_queue_head w_head;
    t_back_stat  w_stat;
    logic        w_pop;

    cis_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (i_item),
        .i_pop   (w_pop),
        .o_head  (w_head)
    );

    cis_back #(
        .MAX_WIDTH   (MAX_WIDTH),
        .MAX_HEIGHT  (MAX_HEIGHT),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_head     (w_head),
        .o_pop      (w_pop),
        .o_stat     (w_stat),
        .o_res      (o_res)
    );

    a_pop_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_head.valid)
        else $error("queue popped while empty");

    a_no_pop_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.busy |-> !w_pop)
        else $error("item taken while a sample is in progress");

    a_ok_needs_map: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($rose(o_res.valid) && o_res.status == STATUS_OK) |-> $past(w_stat.loaded))
        else $error("valid sample produced without a loaded map");

endmodule
